FILE: sv/mfd_pkg.sv
// Shared types, constants and state encodings of the motor feedback frame decoder.
package mfd_pkg;

	// Bit-serial multiply/divide unit widths
	localparam int MD_A_W   = 32;               // multiplicand and divisor width
	localparam int MD_B_W   = 20;               // multiplier width, one bit per step
	localparam int MD_Q_W   = 20;               // quotient width, one bit per step
	localparam int MD_P_W   = MD_A_W + MD_B_W;  // full product width
	localparam int MD_CNT_W = $clog2((MD_B_W > MD_Q_W) ? MD_B_W : MD_Q_W);

	// Field widths
	localparam int POS_W   = 16;
	localparam int RATE_W  = 12;
	localparam int LIMP_W  = 16;
	localparam int LIMR_W  = 20;
	localparam int FAULT_W = 4;
	localparam int ANGLE_W = 20;
	localparam int RVAL_W  = 21;
	localparam int TURN_W  = 32;
	localparam int CFG_IDX_W = 2;

	// Scaling constants
	localparam logic [MD_A_W-1:0] POS_DEN       = 32'hFFFF_0000;  // 65535 * 65536
	localparam logic [MD_A_W-1:0] RATE_DEN      = 32'd4095;
	localparam logic [MD_B_W-1:0] CDEG_PER_MRAD = 20'd375497;
	localparam logic signed [TURN_W-1:0] ONE_TURN_CDEG = 32'sd36000;

	// Register reset values
	localparam logic [LIMP_W-1:0] POS_LIMIT_RST    = 16'd12500;
	localparam logic [LIMR_W-1:0] VEL_LIMIT_RST    = 20'd30000;
	localparam logic [LIMR_W-1:0] TORQUE_LIMIT_RST = 20'd10000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START1,
		ST_WAIT1,
		ST_START2,
		ST_WAIT2,
		ST_SUM,
		ST_TURN
	} top_state_t;

	typedef struct packed {
		logic              start;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_A_W-1:0] divisor;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_P_W-1:0] product;
		logic [MD_Q_W-1:0] quotient;
	} md_rsp_t;

endpackage

FILE: sv/motor_feedback_frame_decoder.sv
// Top level of the motor feedback frame decoder: frame capture, scaling control and turn tracking.
//
// Decodes the first six bytes of a motor feedback frame into fault nibble, shaft angle in
// centidegrees, velocity and torque, and keeps a running turn count. The next frame is
// taken once the previous result has moved into the output register. The processing time
// of a frame is set by the bit-serial multiply/divide units (20 multiply steps plus 20
// quotient steps per pass): velocity and torque each take one pass in parallel, and the
// angle takes two passes back to back on its own unit, first position times limit, then
// times the centidegree-per-milliradian constant followed by the division. A finished
// result sits in an output register, so a new frame is accepted while the old result still
// waits to transfer.
// Configuration writes are always taken (cfg_ready is tied high); index 3 is ignored and data
// above a register's width is dropped. Write limits only while no frame is in flight.
module motor_feedback_frame_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	// frame input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [47:0]                         payload,
	// result output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mfd_pkg::FAULT_W-1:0]         fault_code,
	output logic signed [mfd_pkg::ANGLE_W-1:0]  angle_cdeg,
	output logic signed [mfd_pkg::RVAL_W-1:0]   velocity,
	output logic signed [mfd_pkg::RVAL_W-1:0]   torque,
	output logic signed [mfd_pkg::TURN_W-1:0]   turn_count,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfd_pkg::LIMR_W-1:0]          cfg_data
);
	import mfd_pkg::*;

	top_state_t state_q, state_d;

	// limit registers
	logic [LIMP_W-1:0] pos_lim_q;
	logic [LIMR_W-1:0] vel_lim_q;
	logic [LIMR_W-1:0] tor_lim_q;

	// captured frame: magnitude and sign of each centered raw value
	logic [FAULT_W-1:0] fault_q;
	logic [POS_W-1:0]   pos_mag_q;
	logic               pos_neg_q;
	logic [RATE_W-1:0]  vel_mag_q;
	logic               vel_neg_q;
	logic [RATE_W-1:0]  tor_mag_q;
	logic               tor_neg_q;

	// turn tracking
	logic signed [ANGLE_W-1:0] last_angle_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic [TURN_W-1:0]         sum_q;
	logic [TURN_W-1:0]         revs_q;

	// output register
	logic                      out_valid_q;
	logic [FAULT_W-1:0]        fault_out_q;
	logic signed [ANGLE_W-1:0] angle_out_q;
	logic signed [RVAL_W-1:0]  vel_out_q;
	logic signed [RVAL_W-1:0]  tor_out_q;
	logic [TURN_W-1:0]         revs_out_q;

	md_req_t pos_req, vel_req, tor_req;
	md_rsp_t pos_rsp, vel_rsp, tor_rsp;

	logic in_xfer, out_free, advance, start1, start2;
	logic [POS_W-1:0]          pos_raw;
	logic [RATE_W-1:0]         vel_raw, tor_raw;
	logic signed [ANGLE_W-1:0] angle_val;
	logic [ANGLE_W:0]          delta;
	logic signed [TURN_W-1:0]  sum_s;
	logic                      turn_up, turn_down;
	logic [TURN_W-1:0]         sum_next, revs_next;
	logic [RVAL_W-1:0]         vel_mag_full, tor_mag_full;
	logic [RVAL_W-1:0]         vel_val, tor_val;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign pos_raw = payload[39:24];
	assign vel_raw = payload[23:12];
	assign tor_raw = payload[11:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_START1;
			ST_START1: state_d = ST_WAIT1;
			ST_WAIT1:  if (pos_rsp.done) state_d = ST_START2;
			ST_START2: state_d = ST_WAIT2;
			ST_WAIT2:  if (pos_rsp.done) state_d = ST_SUM;
			ST_SUM:    state_d = ST_TURN;
			ST_TURN:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		start1   = 1'b0;
		start2   = 1'b0;
		advance  = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_START1: start1   = 1'b1;
			ST_START2: start2   = 1'b1;
			ST_TURN:   advance  = out_free;
			default:   ;
		endcase
	end

	// First angle pass forms |c| * limit (fits 32 bits); the second scales it by the
	// centidegree constant and divides by 65535 * 65536.
	assign pos_req.start   = start1 || start2;
	assign pos_req.a       = start2 ? pos_rsp.product[MD_A_W-1:0] : MD_A_W'(pos_mag_q);
	assign pos_req.b       = start2 ? CDEG_PER_MRAD : MD_B_W'(pos_lim_q);
	assign pos_req.divisor = POS_DEN;

	assign vel_req.start   = start1;
	assign vel_req.a       = MD_A_W'(vel_mag_q);
	assign vel_req.b       = vel_lim_q;
	assign vel_req.divisor = RATE_DEN;

	assign tor_req.start   = start1;
	assign tor_req.a       = MD_A_W'(tor_mag_q);
	assign tor_req.b       = tor_lim_q;
	assign tor_req.divisor = RATE_DEN;

	mfd_muldiv u_pos (.clk(clk), .arst_n(arst_n), .req(pos_req), .rsp(pos_rsp));
	mfd_muldiv u_vel (.clk(clk), .arst_n(arst_n), .req(vel_req), .rsp(vel_rsp));
	mfd_muldiv u_tor (.clk(clk), .arst_n(arst_n), .req(tor_req), .rsp(tor_rsp));

	// Apply the sign after the unsigned divide, which gives truncation toward zero.
	assign angle_val = pos_neg_q ? -$signed(pos_rsp.quotient) : $signed(pos_rsp.quotient);
	assign delta     = {angle_val[ANGLE_W-1], angle_val}
	                 - {last_angle_q[ANGLE_W-1], last_angle_q};

	assign vel_mag_full = {1'b0, vel_rsp.quotient};
	assign tor_mag_full = {1'b0, tor_rsp.quotient};
	assign vel_val      = vel_neg_q ? (~vel_mag_full) + RVAL_W'(1) : vel_mag_full;
	assign tor_val      = tor_neg_q ? (~tor_mag_full) + RVAL_W'(1) : tor_mag_full;

	// At most one turn step per frame, past one turn in either direction.
	assign sum_s     = $signed(sum_q);
	assign turn_up   = sum_s > ONE_TURN_CDEG;
	assign turn_down = sum_s < -ONE_TURN_CDEG;
	always_comb begin
		sum_next  = sum_q;
		revs_next = revs_q;
		if (turn_up) begin
			sum_next  = sum_q - ONE_TURN_CDEG;
			revs_next = revs_q + TURN_W'(1);
		end else if (turn_down) begin
			sum_next  = sum_q + ONE_TURN_CDEG;
			revs_next = revs_q - TURN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_lim_q    <= POS_LIMIT_RST;
			vel_lim_q    <= VEL_LIMIT_RST;
			tor_lim_q    <= TORQUE_LIMIT_RST;
			last_angle_q <= '0;
			sum_q        <= '0;
			revs_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POS_LIMIT:    pos_lim_q <= cfg_data[LIMP_W-1:0];
					CFG_VEL_LIMIT:    vel_lim_q <= cfg_data;
					CFG_TORQUE_LIMIT: tor_lim_q <= cfg_data;
					default:          ;
				endcase
			end
			// fold this frame's angle change into the running sum
			if (state_q == ST_SUM) begin
				last_angle_q <= angle_val;
				sum_q        <= sum_q + {{(TURN_W - ANGLE_W - 1){delta[ANGLE_W]}}, delta};
			end
			if (advance) begin
				sum_q  <= sum_next;
				revs_q <= revs_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the frame as magnitude and sign: 2r - full is odd, so its magnitude is the
	// low bits (or their inverse when r sits below mid scale) with a one appended.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fault_q   <= payload[47:44];
			pos_neg_q <= !pos_raw[POS_W-1];
			pos_mag_q <= {pos_raw[POS_W-1] ? pos_raw[POS_W-2:0] : ~pos_raw[POS_W-2:0], 1'b1};
			vel_neg_q <= !vel_raw[RATE_W-1];
			vel_mag_q <= {vel_raw[RATE_W-1] ? vel_raw[RATE_W-2:0] : ~vel_raw[RATE_W-2:0], 1'b1};
			tor_neg_q <= !tor_raw[RATE_W-1];
			tor_mag_q <= {tor_raw[RATE_W-1] ? tor_raw[RATE_W-2:0] : ~tor_raw[RATE_W-2:0], 1'b1};
		end
		if (state_q == ST_SUM) begin
			angle_q <= angle_val;
		end
		if (advance) begin
			fault_out_q <= fault_q;
			angle_out_q <= angle_q;
			vel_out_q   <= $signed(vel_val);
			tor_out_q   <= $signed(tor_val);
			revs_out_q  <= revs_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign fault_code = fault_out_q;
	assign angle_cdeg = angle_out_q;
	assign velocity   = vel_out_q;
	assign torque     = tor_out_q;
	assign turn_count = $signed(revs_out_q);

endmodule

FILE: sv/mfd_muldiv.sv
// Bit-serial unit: floor(a * b / divisor), one multiplier bit then one quotient bit per cycle.
module mfd_muldiv (
	input  logic            clk,
	input  logic            arst_n,
	input  mfd_pkg::md_req_t req,
	output mfd_pkg::md_rsp_t rsp
);
	import mfd_pkg::*;

	md_state_t state_q, state_d;
	logic [MD_CNT_W-1:0] cnt_q;
	logic                done_q;
	logic [MD_A_W-1:0]   a_q;
	logic [MD_B_W-1:0]   b_q;
	logic [MD_A_W-1:0]   div_q;
	logic [MD_P_W-1:0]   acc_q;
	logic [MD_A_W-1:0]   rem_q;
	logic [MD_Q_W-1:0]   low_q;
	logic [MD_Q_W-1:0]   quo_q;

	logic                do_load, do_mul, do_div, mul_last, div_last;
	logic [MD_P_W-1:0]   acc_next;
	logic [MD_A_W:0]     trial;
	logic [MD_A_W:0]     trial_diff;
	logic                fits;

	assign mul_last = (cnt_q == MD_CNT_W'(MD_B_W - 1));
	assign div_last = (cnt_q == MD_CNT_W'(MD_Q_W - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: if (req.start) state_d = MD_MUL;
			MD_MUL:  if (mul_last) state_d = MD_DIV;
			MD_DIV:  if (div_last) state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	// step controls
	always_comb begin
		do_load = 1'b0;
		do_mul  = 1'b0;
		do_div  = 1'b0;
		case (state_q)
			MD_IDLE: do_load = req.start;
			MD_MUL:  do_mul  = 1'b1;
			MD_DIV:  do_div  = 1'b1;
			default: ;
		endcase
	end

	// MSB-first shift and add
	assign acc_next   = {acc_q[MD_P_W-2:0], 1'b0} + (b_q[MD_B_W-1] ? MD_P_W'(a_q) : '0);
	// restoring divide step
	assign trial      = {rem_q, low_q[MD_Q_W-1]};
	assign trial_diff = trial - {1'b0, div_q};
	assign fits       = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= do_div && div_last;
			if (do_load || (do_mul && mul_last) || (do_div && div_last)) begin
				cnt_q <= '0;
			end else if (do_mul || do_div) begin
				cnt_q <= cnt_q + MD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			a_q   <= req.a;
			b_q   <= req.b;
			div_q <= req.divisor;
			acc_q <= '0;
		end
		if (do_mul) begin
			acc_q <= acc_next;
			b_q   <= {b_q[MD_B_W-2:0], 1'b0};
			if (mul_last) begin
				rem_q <= acc_next[MD_P_W-1 -: MD_A_W];
				low_q <= acc_next[MD_Q_W-1:0];
			end
		end
		if (do_div) begin
			rem_q <= fits ? trial_diff[MD_A_W-1:0] : trial[MD_A_W-1:0];
			low_q <= {low_q[MD_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[MD_Q_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.product  = acc_q;
	assign rsp.quotient = quo_q;

endmodule
